// File: rtl/rgbhsl_pkg.sv
package rgbhsl_pkg;

    // Channel and field widths
    localparam int CH_W = 8;

    // Divider geometry: both quotients are known to stay below 256, so an
    // 8-step restoring division of a 17-bit numerator by a 9-bit divisor
    // starts with the top 9 numerator bits as the partial remainder.
    localparam int DIV_NUM_W   = 17;
    localparam int DIV_DEN_W   = 9;
    localparam int DIV_Q_W     = 8;
    localparam int DIV_LOW_W   = DIV_NUM_W - DIV_DEN_W;
    localparam int DIV_BPS     = 2;
    localparam int DIV_STAGES  = DIV_Q_W / DIV_BPS;

    // Pipeline depth ahead of the output register
    localparam int PREP_STAGES = 2;
    localparam int PIPE_VLD    = PREP_STAGES + DIV_STAGES;

    // Hue constants in half degrees
    localparam logic [7:0] HUE_FULL  = 8'd180;
    localparam logic [7:0] OFF_RED   = 8'd180;
    localparam logic [7:0] OFF_GREEN = 8'd60;
    localparam logic [7:0] OFF_BLUE  = 8'd120;
    localparam logic [7:0] HUE_MAX_Q = 8'd210;

    // Channel full scale and its double
    localparam logic [7:0] CH_MAX    = 8'd255;
    localparam logic [9:0] CH_MAX_X2 = 10'd510;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    typedef struct packed {
        logic                grey;
        logic [CH_W-1:0]     light;
    } side_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] hue_num;
        logic [DIV_DEN_W-1:0] hue_den;
        logic [DIV_NUM_W-1:0] sat_num;
        logic [DIV_DEN_W-1:0] sat_den;
        side_t                side;
    } prep_t;

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DIV_DEN_W:0] div_step(
        input logic [DIV_DEN_W-1:0] rem,
        input logic [DIV_DEN_W-1:0] den,
        input logic                 nbit
    );
        logic [DIV_DEN_W:0] trial;
        logic [DIV_DEN_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
            return {1'b1, diff[DIV_DEN_W-1:0]};
        else
            return {1'b0, trial[DIV_DEN_W-1:0]};
    endfunction

endpackage

// File: rtl/rgbhsl_prep.sv
module rgbhsl_prep (
    input  logic                           clk,
    input  logic                           advance,
    input  logic [rgbhsl_pkg::CH_W-1:0]    red,
    input  logic [rgbhsl_pkg::CH_W-1:0]    green,
    input  logic [rgbhsl_pkg::CH_W-1:0]    blue,
    output rgbhsl_pkg::prep_t              prep
);

    // Stage one: extremes, leading channel, signed channel difference
    logic [7:0]                 mx;
    logic [7:0]                 mn;
    rgbhsl_pkg::max_sel_t       sel_next;
    logic signed [8:0]          diff_next;

    rgbhsl_pkg::max_sel_t       sel_reg;
    logic signed [8:0]          diff_reg;
    logic [7:0]                 d_reg;
    logic [8:0]                 sum_reg;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;

        // Red wins ties, then green
        if (red == mx)
        begin
            sel_next  = rgbhsl_pkg::SEL_RED;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green == mx)
        begin
            sel_next  = rgbhsl_pkg::SEL_GREEN;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sel_next  = rgbhsl_pkg::SEL_BLUE;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sel_reg  <= sel_next;
            diff_reg <= diff_next;
            d_reg    <= mx - mn;
            sum_reg  <= {1'b0, mx} + {1'b0, mn};
        end
    end

    // Stage two: numerators and divisors for both rounded divisions
    logic [7:0]          off;
    logic [15:0]         off_d;
    logic signed [13:0]  diff_ext;
    logic signed [13:0]  thirty_diff;
    logic signed [17:0]  t_wide;
    logic [7:0]          sat_base;
    logic [9:0]          light_sum;
    rgbhsl_pkg::prep_t   prep_next;
    rgbhsl_pkg::prep_t   prep_reg;

    always_comb
    begin
        case (sel_reg)
            rgbhsl_pkg::SEL_RED:   off = rgbhsl_pkg::OFF_RED;
            rgbhsl_pkg::SEL_GREEN: off = rgbhsl_pkg::OFF_GREEN;
            rgbhsl_pkg::SEL_BLUE:  off = rgbhsl_pkg::OFF_BLUE;
            default:               off = rgbhsl_pkg::OFF_BLUE;
        endcase

        off_d       = {8'd0, off} * {8'd0, d_reg};
        diff_ext    = 14'(diff_reg);
        thirty_diff = (diff_ext <<< 5) - (diff_ext <<< 1);
        t_wide      = $signed({2'b00, off_d}) + 18'(thirty_diff);

        // Divisor of the saturation depends on which half lightness is in
        if (sum_reg <= {1'b0, rgbhsl_pkg::CH_MAX})
            sat_base = sum_reg[7:0];
        else
            sat_base = 8'(rgbhsl_pkg::CH_MAX_X2 - {1'b0, sum_reg});

        light_sum = {1'b0, sum_reg} + 10'd1;

        prep_next.hue_num    = {t_wide[15:0], 1'b0} + {9'd0, d_reg};
        prep_next.hue_den    = {d_reg, 1'b0};
        prep_next.sat_num    = 17'({9'd0, d_reg} * {7'd0, rgbhsl_pkg::CH_MAX_X2})
                               + {9'd0, sat_base};
        prep_next.sat_den    = {sat_base, 1'b0};
        prep_next.side.grey  = (d_reg == 8'd0);
        prep_next.side.light = light_sum[8:1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            prep_reg <= prep_next;
    end

    assign prep = prep_reg;

endmodule

// File: rtl/rgbhsl_div.sv
module rgbhsl_div (
    input  logic                                clk,
    input  logic                                advance,
    input  logic [rgbhsl_pkg::DIV_NUM_W-1:0]    num,
    input  logic [rgbhsl_pkg::DIV_DEN_W-1:0]    den,
    output logic [rgbhsl_pkg::DIV_Q_W-1:0]      quo
);

    logic [rgbhsl_pkg::DIV_DEN_W-1:0] rem_reg [rgbhsl_pkg::DIV_STAGES];
    logic [rgbhsl_pkg::DIV_DEN_W-1:0] den_reg [rgbhsl_pkg::DIV_STAGES];
    logic [rgbhsl_pkg::DIV_LOW_W-1:0] low_reg [rgbhsl_pkg::DIV_STAGES];
    logic [rgbhsl_pkg::DIV_Q_W-1:0]   quo_reg [rgbhsl_pkg::DIV_STAGES];

    for (genvar k = 0; k < rgbhsl_pkg::DIV_STAGES; k++)
    begin : g_stage
        logic [rgbhsl_pkg::DIV_DEN_W-1:0] rem_in;
        logic [rgbhsl_pkg::DIV_DEN_W-1:0] den_in;
        logic [rgbhsl_pkg::DIV_LOW_W-1:0] low_in;
        logic [rgbhsl_pkg::DIV_Q_W-1:0]   quo_in;
        logic [rgbhsl_pkg::DIV_DEN_W-1:0] rem_next;
        logic [rgbhsl_pkg::DIV_LOW_W-1:0] low_next;
        logic [rgbhsl_pkg::DIV_Q_W-1:0]   quo_next;
        logic [rgbhsl_pkg::DIV_DEN_W:0]   step;

        // Take operands from the ports or from the previous stage
        if (k == 0)
        begin : g_first
            assign rem_in = num[rgbhsl_pkg::DIV_NUM_W-1:rgbhsl_pkg::DIV_LOW_W];
            assign low_in = num[rgbhsl_pkg::DIV_LOW_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Retire two quotient bits per stage
        always_comb
        begin
            rem_next = rem_in;
            low_next = low_in;
            quo_next = quo_in;
            step     = '0;
            for (int j = 0; j < rgbhsl_pkg::DIV_BPS; j++)
            begin
                step     = rgbhsl_pkg::div_step(rem_next, den_in,
                                                low_next[rgbhsl_pkg::DIV_LOW_W-1]);
                rem_next = step[rgbhsl_pkg::DIV_DEN_W-1:0];
                quo_next = {quo_next[rgbhsl_pkg::DIV_Q_W-2:0],
                            step[rgbhsl_pkg::DIV_DEN_W]};
                low_next = {low_next[rgbhsl_pkg::DIV_LOW_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                low_reg[k] <= low_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[rgbhsl_pkg::DIV_STAGES-1];

endmodule

// File: rtl/rgb_to_hsl_pixel.sv
// RGB to HSL pixel converter.
// Slave stream (s_axis_*) takes one RGB pixel per item; master stream
// (m_axis_*) returns one HSL pixel per item, in the same order.
// Hue comes out in half degrees (0..179), lightness and saturation on a
// 0..255 scale, all rounded to nearest. Grey pixels give hue 0 and
// saturation 0.
// Throughput: one item per cycle while the receiver does not stall.
// Depth: seven register stages, made up of two preparation stages, four
// divider stages (two quotient bits each, for hue and saturation side by
// side) and the output register.
// The whole pipeline moves as one: it advances whenever the output
// register is empty or being taken. When the receiver stalls with a
// result pending, every stage holds and s_axis_tready drops in the same
// cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block holds no state between pixels
// and is ready for an item in the first cycle after reset.
module rgb_to_hsl_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue_half_deg [7:0], lightness [15:8],
                                        // saturation [23:16]
);

    logic                                   advance;
    logic [rgbhsl_pkg::PIPE_VLD-1:0]        vld_reg;
    logic [rgbhsl_pkg::PIPE_VLD-1:0]        vld_next;
    logic                                   m_vld_reg;
    logic                                   m_vld_next;
    rgbhsl_pkg::prep_t                      prep;
    rgbhsl_pkg::side_t                      side_reg [rgbhsl_pkg::DIV_STAGES];
    logic [rgbhsl_pkg::DIV_Q_W-1:0]         hue_q;
    logic [rgbhsl_pkg::DIV_Q_W-1:0]         sat_q;
    logic [7:0]                             hue_out;
    logic [23:0]                            m_data_next;
    logic [23:0]                            m_data_reg;
    rgbhsl_pkg::side_t                      side_out;

    // Advance when the output slot is free or being taken
    assign advance       = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = advance;

    rgbhsl_prep u_prep (
        .clk     (clk),
        .advance (advance),
        .red     (s_axis_tdata[7:0]),
        .green   (s_axis_tdata[15:8]),
        .blue    (s_axis_tdata[23:16]),
        .prep    (prep)
    );

    rgbhsl_div u_hue_div (
        .clk     (clk),
        .advance (advance),
        .num     (prep.hue_num),
        .den     (prep.hue_den),
        .quo     (hue_q)
    );

    rgbhsl_div u_sat_div (
        .clk     (clk),
        .advance (advance),
        .num     (prep.sat_num),
        .den     (prep.sat_den),
        .quo     (sat_q)
    );

    // Carry lightness and the grey flag alongside the dividers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= prep.side;
            for (int k = 1; k < rgbhsl_pkg::DIV_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign side_out = side_reg[rgbhsl_pkg::DIV_STAGES-1];

    // Wrap hue, zero hue and saturation for grey pixels
    always_comb
    begin
        if (hue_q >= rgbhsl_pkg::HUE_FULL)
            hue_out = hue_q - rgbhsl_pkg::HUE_FULL;
        else
            hue_out = hue_q;

        if (side_out.grey)
            m_data_next = {8'd0, side_out.light, 8'd0};
        else
            m_data_next = {sat_q, side_out.light, hue_out};
    end

    // Shift valid bits with the data
    always_comb
    begin
        vld_next   = vld_reg;
        m_vld_next = m_vld_reg;
        if (advance)
        begin
            vld_next   = {vld_reg[rgbhsl_pkg::PIPE_VLD-2:0], s_axis_tvalid};
            m_vld_next = vld_reg[rgbhsl_pkg::PIPE_VLD-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            m_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;

    // Uninterrupted pipeline presents an accepted item once it has advanced through every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 advance ##1 advance ##1 advance
            ##1 advance ##1 advance ##1 advance |=> m_axis_tvalid)
        else $error("accepted item did not reach the output on time");

    // A stall freezes every valid bit in the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // Hue quotient stays within one wrap for colored pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[rgbhsl_pkg::PIPE_VLD-1] && !side_out.grey)
            |-> (hue_q <= rgbhsl_pkg::HUE_MAX_Q))
        else $error("hue quotient out of range");

    // Delivered hue is always wrapped into half-degree range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] < rgbhsl_pkg::HUE_FULL))
        else $error("hue not wrapped");

endmodule
